>>> rtl/imp_pkg.sv
// ----------------------------------------------------------------------------
// imp_pkg - shared types and constants for the integer matrix power block
// Matrix geometry, store addressing, register indexes and MAC control types.
// ----------------------------------------------------------------------------
package imp_pkg;

  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;          // address = {row, col}
  localparam int CELLS   = 1 << ADDR_W;
  localparam int DATA_W  = 32;
  localparam int DIM_W   = 4;
  localparam int EXP_W   = 16;
  localparam int CFG_W   = 16;                 // widest register
  localparam int MAC_LAT = 3;                  // MAC span from issue to store write
  localparam int DRAIN_W = (MAC_LAT > 1) ? $clog2(MAC_LAT) : 1;

  // register indexes
  localparam logic REG_DIM      = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              first;   // first term of a dot product
    logic              last;    // last term, result goes to the store
    logic [ADDR_W-1:0] waddr;
  } mac_ctl_t;

  typedef struct packed {
    logic              wen;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
  } mac_wr_t;

  // side length minus one, with zero taken as one and oversize clamped
  function automatic logic [IDX_W-1:0] side_m1(input logic [DIM_W-1:0] d);
    logic [IDX_W-1:0] res;
    if (d == '0) begin
      res = '0;
    end else if (32'(d) > MAX_DIM) begin
      res = IDX_W'(MAX_DIM - 1);
    end else begin
      res = IDX_W'(d - DIM_W'(1));
    end
    return res;
  endfunction

endpackage

>>> rtl/imp_ram.sv
// ----------------------------------------------------------------------------
// imp_ram - simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module imp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/imp_mac.sv
// ----------------------------------------------------------------------------
// imp_mac - shared multiply-accumulate unit
// Multiply stage then accumulate stage; emits a store write on the last term.
// ----------------------------------------------------------------------------
module imp_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  imp_pkg::mac_ctl_t            issue,   // aligned with read addresses
  input  logic [imp_pkg::DATA_W-1:0]   a,       // read data, the cycle after the issue
  input  logic [imp_pkg::DATA_W-1:0]   b,
  output imp_pkg::mac_wr_t             wr
);

  imp_pkg::mac_ctl_t          ctl1;
  imp_pkg::mac_ctl_t          ctl2;
  logic [imp_pkg::DATA_W-1:0] prod;
  logic [imp_pkg::DATA_W-1:0] acc;
  logic [imp_pkg::DATA_W-1:0] sum;

  assign sum = (ctl2.first ? '0 : acc) + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1   <= '0;
      ctl2   <= '0;
      wr.wen <= 1'b0;
    end else begin
      ctl1   <= issue;
      ctl2   <= ctl1;
      wr.wen <= ctl2.valid && ctl2.last;
    end
    // low 32 bits only: wraps as C int arithmetic
    if (ctl1.valid) begin
      prod <= a * b;
    end
    if (ctl2.valid) begin
      acc <= sum;
    end
    wr.waddr <= ctl2.waddr;
    wr.wdata <= sum;
  end

endmodule

>>> rtl/imp_seq.sv
// ----------------------------------------------------------------------------
// imp_seq - multiplication sequencer
// Walks row, column and term indexes for each round and drains the MAC.
// ----------------------------------------------------------------------------
module imp_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [imp_pkg::IDX_W-1:0]   n_m1,
  input  logic [imp_pkg::EXP_W-1:0]   rounds,
  output imp_pkg::mac_ctl_t           issue,
  output logic [imp_pkg::ADDR_W-1:0]  pa,      // power store, {r, t}
  output logic [imp_pkg::ADDR_W-1:0]  sa,      // source store, {t, c}
  output logic                        swap,    // round complete, flip banks
  output logic                        done
);

  typedef enum logic [1:0] {IDLE, RUN, DRAIN} state_t;

  state_t                      state;
  logic [imp_pkg::IDX_W-1:0]   r;
  logic [imp_pkg::IDX_W-1:0]   c;
  logic [imp_pkg::IDX_W-1:0]   t;
  logic [imp_pkg::EXP_W-1:0]   round_count;
  logic [imp_pkg::DRAIN_W-1:0] drain;
  logic                        drain_end;

  assign pa          = {r, t};
  assign sa          = {t, c};
  assign issue.valid = (state == RUN);
  assign issue.first = (t == '0);
  assign issue.last  = (t == n_m1);
  assign issue.waddr = {r, c};

  assign drain_end = (state == DRAIN) && (drain == imp_pkg::DRAIN_W'(imp_pkg::MAC_LAT - 1));
  assign swap      = drain_end;
  assign done      = drain_end && (round_count + imp_pkg::EXP_W'(1) == rounds);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      r           <= '0;
      c           <= '0;
      t           <= '0;
      round_count <= '0;
      drain       <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            r           <= '0;
            c           <= '0;
            t           <= '0;
            round_count <= '0;
            state       <= RUN;
          end
        end
        RUN: begin
          if (t == n_m1) begin
            t <= '0;
            if (c == n_m1) begin
              c <= '0;
              if (r == n_m1) begin
                r     <= '0;
                drain <= '0;
                state <= DRAIN;
              end else begin
                r <= r + imp_pkg::IDX_W'(1);
              end
            end else begin
              c <= c + imp_pkg::IDX_W'(1);
            end
          end else begin
            t <= t + imp_pkg::IDX_W'(1);
          end
        end
        DRAIN: begin
          drain <= drain + imp_pkg::DRAIN_W'(1);
          if (drain_end) begin
            round_count <= round_count + imp_pkg::EXP_W'(1);
            state       <= done ? IDLE : RUN;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> rtl/integer_matrix_power.sv
// ----------------------------------------------------------------------------
// integer_matrix_power - square integer matrix raised to a power
// Loads a matrix row-major, multiplies it repeatedly on a shared MAC and
// streams the power out row-major with tlast on the final entry.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat carries                          notes
//  s_*      in   element                               one beat per cycle in load
//  m_*      out  value, row, col; tlast = last entry   dim*dim beats per matrix
//  cfg_*    in   dim (index 0), exponent (index 1)     write while idle only
//
// Sequence: elements are taken in load. After the last element, an exponent
// above one costs a start strobe and (exponent-1) rounds of dim^3 MAC terms
// (one MAC term per cycle on the single multiplier) plus the pipeline drain;
// then the store read is primed and the output beats stream out.
// Reset: state, load position, dim = 1, exponent = 1; stores are left as is.
// Stalls: s_tready low from the last element to the last beat; m_tready low holds.
//
module integer_matrix_power (
  input  logic                        clk,
  input  logic                        rst,
  // element[31:0]
  input  logic [31:0]                 s_tdata,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // value[31:0], row[34:32], col[37:35], zero pad[39:38]
  output logic [39:0]                 m_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic                        m_tlast,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [imp_pkg::CFG_W-1:0]   cfg_data
);

  typedef enum logic [1:0] {LOAD, COMPUTE, PREP, SHOW} state_t;

  state_t                       state;
  logic [imp_pkg::DIM_W-1:0]    dim;
  logic [imp_pkg::EXP_W-1:0]    exponent;
  logic [imp_pkg::EXP_W-1:0]    rounds;
  logic                         exp_zero;
  logic                         cur;         // bank holding the running power
  logic                         seq_start;
  logic [imp_pkg::IDX_W-1:0]    ld_r;
  logic [imp_pkg::IDX_W-1:0]    ld_c;
  logic [imp_pkg::IDX_W-1:0]    out_r;
  logic [imp_pkg::IDX_W-1:0]    out_c;
  logic [imp_pkg::IDX_W-1:0]    out_r_next;
  logic [imp_pkg::IDX_W-1:0]    out_c_next;
  logic [imp_pkg::IDX_W-1:0]    n_m1;

  logic                         s_accept;
  logic                         m_accept;
  logic                         out_last;

  imp_pkg::mac_ctl_t            issue;
  imp_pkg::mac_wr_t             wr;
  logic [imp_pkg::ADDR_W-1:0]   pa;
  logic [imp_pkg::ADDR_W-1:0]   sa;
  logic                         seq_swap;
  logic                         seq_done;

  logic [imp_pkg::ADDR_W-1:0]   ld_addr;
  logic [imp_pkg::ADDR_W-1:0]   bank_raddr;
  logic                         bank0_we;
  logic                         bank1_we;
  logic [imp_pkg::ADDR_W-1:0]   bank0_waddr;
  logic [imp_pkg::DATA_W-1:0]   bank0_wdata;
  logic [imp_pkg::DATA_W-1:0]   bank0_rdata;
  logic [imp_pkg::DATA_W-1:0]   bank1_rdata;
  logic [imp_pkg::DATA_W-1:0]   src_rdata;
  logic [imp_pkg::DATA_W-1:0]   pow_rdata;
  logic [imp_pkg::DATA_W-1:0]   out_value;

  assign n_m1     = imp_pkg::side_m1(dim);
  assign s_tready = (state == LOAD);
  assign s_accept = s_tvalid && s_tready;
  assign m_tvalid = (state == SHOW);
  assign m_accept = m_tvalid && m_tready;
  assign out_last = (out_r == n_m1) && (out_c == n_m1);
  assign ld_addr  = {ld_r, ld_c};

  // next output position; the store is read at it so data lines up with the registered position
  always_comb begin
    out_r_next = out_r;
    out_c_next = out_c;
    case (state)
      PREP: begin
        out_r_next = '0;
        out_c_next = '0;
      end
      SHOW: begin
        if (m_accept && !out_last) begin
          if (out_c == n_m1) begin
            out_c_next = '0;
            out_r_next = out_r + imp_pkg::IDX_W'(1);
          end else begin
            out_c_next = out_c + imp_pkg::IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= LOAD;
      dim       <= imp_pkg::DIM_W'(1);
      exponent  <= imp_pkg::EXP_W'(1);
      rounds    <= '0;
      exp_zero  <= 1'b0;
      cur       <= 1'b0;
      seq_start <= 1'b0;
      ld_r      <= '0;
      ld_c      <= '0;
      out_r     <= '0;
      out_c     <= '0;
    end else begin
      seq_start <= 1'b0;
      out_r     <= out_r_next;
      out_c     <= out_c_next;
      case (state)
        LOAD: begin
          if (s_accept) begin
            if (ld_c == n_m1) begin
              ld_c <= '0;
              if (ld_r == n_m1) begin
                // last element: elements were also written to bank 0
                ld_r     <= '0;
                cur      <= 1'b0;
                exp_zero <= (exponent == '0);
                rounds   <= exponent - imp_pkg::EXP_W'(1);
                if (exponent > imp_pkg::EXP_W'(1)) begin
                  seq_start <= 1'b1;
                  state     <= COMPUTE;
                end else begin
                  state <= PREP;
                end
              end else begin
                ld_r <= ld_r + imp_pkg::IDX_W'(1);
              end
            end else begin
              ld_c <= ld_c + imp_pkg::IDX_W'(1);
            end
          end
        end
        COMPUTE: begin
          if (seq_swap) begin
            cur <= ~cur;
          end
          if (seq_done) begin
            state <= PREP;
          end
        end
        PREP: state <= SHOW;
        SHOW: begin
          if (m_accept && out_last) begin
            state <= LOAD;
          end
        end
        default: state <= LOAD;
      endcase
      // a dim write restarts the load
      if (cfg_we) begin
        case (cfg_index)
          imp_pkg::REG_DIM: begin
            dim  <= cfg_data[imp_pkg::DIM_W-1:0];
            ld_r <= '0;
            ld_c <= '0;
          end
          imp_pkg::REG_EXPONENT: exponent <= cfg_data[imp_pkg::EXP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // stores: source, and two power banks used ping-pong (running power / product)
  assign bank_raddr  = (state == COMPUTE) ? pa : {out_r_next, out_c_next};
  assign bank0_we    = s_accept || (wr.wen && cur);
  assign bank1_we    = wr.wen && !cur;
  assign bank0_waddr = s_accept ? ld_addr : wr.waddr;
  assign bank0_wdata = s_accept ? s_tdata : wr.wdata;
  assign pow_rdata   = cur ? bank1_rdata : bank0_rdata;

  imp_ram #(.WIDTH(imp_pkg::DATA_W), .DEPTH(imp_pkg::CELLS)) u_src (
    .clk   (clk),
    .we    (s_accept),
    .waddr (ld_addr),
    .wdata (s_tdata),
    .raddr (sa),
    .rdata (src_rdata)
  );

  imp_ram #(.WIDTH(imp_pkg::DATA_W), .DEPTH(imp_pkg::CELLS)) u_bank0 (
    .clk   (clk),
    .we    (bank0_we),
    .waddr (bank0_waddr),
    .wdata (bank0_wdata),
    .raddr (bank_raddr),
    .rdata (bank0_rdata)
  );

  imp_ram #(.WIDTH(imp_pkg::DATA_W), .DEPTH(imp_pkg::CELLS)) u_bank1 (
    .clk   (clk),
    .we    (bank1_we),
    .waddr (wr.waddr),
    .wdata (wr.wdata),
    .raddr (bank_raddr),
    .rdata (bank1_rdata)
  );

  imp_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (seq_start),
    .n_m1   (n_m1),
    .rounds (rounds),
    .issue  (issue),
    .pa     (pa),
    .sa     (sa),
    .swap   (seq_swap),
    .done   (seq_done)
  );

  imp_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .a     (pow_rdata),
    .b     (src_rdata),
    .wr    (wr)
  );

  // exponent zero: identity, no store read needed
  assign out_value = exp_zero ? ((out_r == out_c) ? imp_pkg::DATA_W'(1) : '0) : pow_rdata;
  assign m_tdata   = {2'b00, out_c, out_r, out_value};
  assign m_tlast   = out_last;

endmodule

>>> rtl/imp_checker.sv
// ----------------------------------------------------------------------------
// imp_checker - port-level assertions for integer_matrix_power
// Watches the stream ports; bound to the top level below.
// ----------------------------------------------------------------------------
module imp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  // input side closed while results go out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("s_tready and m_tvalid high together");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output beat changed under stall");

  // final entry sits on the diagonal
  a_last_diag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[37:35] == m_tdata[34:32]))
    else $error("last beat off the diagonal");

  // after the last beat the block returns to loading
  a_last_reload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
    else $error("no return to load after last beat");

endmodule

bind integer_matrix_power imp_checker u_imp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> dv/integer_matrix_power_tb.sv
// ----------------------------------------------------------------------------
// integer_matrix_power_tb - self-checking bench for the integer matrix power
// Streams matrices in through the slave port and programs dim and exponent
// through the write port. Every beat out is checked against a behavioural
// model of the power held in the bench. A short table of directed rows comes
// first, then random phases with varying geometry, exponent and back-pressure.
// ----------------------------------------------------------------------------
module integer_matrix_power_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = imp_pkg::MAC_LAT + 8;  // quiet time before a register write
  localparam int DRAIN_CYCLES  = 64;            // watch for stray beats at the end
  localparam int ITEM_TARGET   = 370;           // elements to stream before the random phases stop
  localparam int PRINT_CAP     = 100;

  // one output beat as the bench sees it
  typedef struct packed {
    logic [imp_pkg::DATA_W-1:0] value;
    logic [2:0]                 row;
    logic [2:0]                 col;
    logic                       last;
  } entry_t;

  typedef enum logic [1:0] {ROW_ELEM, ROW_DIM, ROW_EXP} row_kind_e;

  // directed row: element beat or register write; want is only used when typed
  typedef struct packed {
    row_kind_e                  kind;
    logic [imp_pkg::DATA_W-1:0] data;
    logic                       typed;
    logic [imp_pkg::DATA_W-1:0] want;
  } plan_row_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idling_e;

  localparam int PLAN_LEN = 36;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // straight after reset: 1x1, power 1, so the element comes straight back
    '{ROW_ELEM, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{ROW_ELEM, 32'h8000_0000, 1'b1, 32'h8000_0000},
    // power zero gives the identity whatever was loaded
    '{ROW_EXP,  32'h0000_0000, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h1234_5678, 1'b1, 32'h0000_0001},
    // squares, two of which wrap
    '{ROW_EXP,  32'h0000_0002, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h8000_0000, 1'b1, 32'h0000_0000},
    '{ROW_ELEM, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
    '{ROW_ELEM, 32'h0000_FFFF, 1'b1, 32'hFFFE_0001},
    // largest exponent, kept to a 1x1 matrix so the run stays short
    '{ROW_EXP,  32'h0000_FFFF, 1'b0, 32'h0},
    '{ROW_ELEM, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    // dim of zero behaves as one
    '{ROW_DIM,  32'h0000_5A50, 1'b0, 32'h0},
    '{ROW_EXP,  32'h0000_0003, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h0000_0002, 1'b1, 32'h0000_0008},
    '{ROW_ELEM, 32'h8000_0001, 1'b0, 32'h0},
    // 2x2 squared, junk in the unused bits of the dim write
    '{ROW_DIM,  32'h0000_ABC2, 1'b0, 32'h0},
    '{ROW_EXP,  32'h0000_0002, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h0000_0001, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h0000_0002, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h0000_0003, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h0000_0004, 1'b0, 32'h0},
    // dim rewritten part way through a load: the partial 3x3 is dropped
    '{ROW_DIM,  32'h0000_0003, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h0000_0005, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h0000_0006, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h0000_0007, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h0000_0008, 1'b0, 32'h0},
    '{ROW_DIM,  32'h0000_F002, 1'b0, 32'h0},
    '{ROW_ELEM, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h0000_0002, 1'b0, 32'h0},
    // exponent rewritten mid-load: the value at the last element counts
    '{ROW_EXP,  32'h0000_0001, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h0000_000A, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h0000_0014, 1'b0, 32'h0},
    '{ROW_EXP,  32'h0000_0004, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h0000_001E, 1'b0, 32'h0},
    '{ROW_ELEM, 32'h0000_0028, 1'b0, 32'h0}
  };

  logic                       clk = 1'b0;
  logic                       rst;
  logic [31:0]                s_tdata;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [39:0]                m_tdata;
  logic                       m_tvalid;
  logic                       m_tready;
  logic                       m_tlast;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [imp_pkg::CFG_W-1:0]  cfg_data;

  // bench copy of the block's registers and stores
  logic [imp_pkg::DIM_W-1:0]  cur_dim;
  logic [imp_pkg::EXP_W-1:0]  cur_exp;
  int unsigned                fill;
  logic [imp_pkg::DATA_W-1:0] src_m  [imp_pkg::MAX_DIM][imp_pkg::MAX_DIM];
  logic [imp_pkg::DATA_W-1:0] pow_m  [imp_pkg::MAX_DIM][imp_pkg::MAX_DIM];
  logic [imp_pkg::DATA_W-1:0] prod_m [imp_pkg::MAX_DIM][imp_pkg::MAX_DIM];

  entry_t            power_beats_q [$];   // beats still owed by the block
  int unsigned       mismatches;
  int unsigned       elements_sent;
  int unsigned       send_gap_pct;
  int unsigned       recv_stall_pct;

  integer_matrix_power dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("%0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  // effective side length: zero reads as one, oversize clamps to MAX_DIM
  function automatic int unsigned side_len(input logic [imp_pkg::DIM_W-1:0] d);
    if (d == '0) return 1;
    if (int'(d) > imp_pkg::MAX_DIM) return imp_pkg::MAX_DIM;
    return int'(d);
  endfunction

  function automatic logic [imp_pkg::DATA_W-1:0] rand_element();
    int v;
    logic [imp_pkg::DATA_W-1:0] e;
    case ($urandom_range(0, 3))
      0: begin
        v = int'($urandom_range(0, 8)) - 4;     // small signed, keeps powers readable
        e = imp_pkg::DATA_W'(v);
      end
      1: begin
        case ($urandom_range(0, 4))
          0: e = 32'h8000_0000;
          1: e = 32'h7FFF_FFFF;
          2: e = 32'h0000_0000;
          3: e = 32'h0000_0001;
          default: e = 32'hFFFF_FFFF;
        endcase
      end
      default: e = $urandom;
    endcase
    return e;
  endfunction

  // big matrices get short exponents so the compute phase stays bounded
  function automatic logic [imp_pkg::EXP_W-1:0] pick_exponent(input int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (n >= 6) return imp_pkg::EXP_W'($urandom_range(0, 4));
    if (r < 15) return '0;
    if (r < 30) return imp_pkg::EXP_W'(1);
    if (r < 85) return imp_pkg::EXP_W'($urandom_range(2, 6));
    return imp_pkg::EXP_W'($urandom_range(7, (n <= 2) ? 60 : 20));
  endfunction

  task automatic set_idling(input idling_e mode);
    case (mode)
      IDLE_NONE: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_gap_pct = 61; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_gap_pct = 0;  recv_stall_pct = 61; end
      default:   begin send_gap_pct = 26; recv_stall_pct = 26; end
    endcase
  endtask

  // Register write. Drops the element stream, waits until every owed beat has
  // been taken and the block has had time to settle, then writes and mirrors
  // the effect in the model.
  task automatic write_reg(input logic idx, input logic [imp_pkg::CFG_W-1:0] data);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (power_beats_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == imp_pkg::REG_DIM) begin
      cur_dim = data[imp_pkg::DIM_W-1:0];
      fill    = 0;                              // a dim write restarts the load
    end else begin
      cur_exp = data[imp_pkg::EXP_W-1:0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drive one element beat and, once it is taken, load it into the model.
  // On the last element of a matrix the power is worked out and its beats are
  // queued; a typed row replaces the single 1x1 beat with the table's value.
  task automatic send_element(input logic [imp_pkg::DATA_W-1:0] e, input logic typed,
                              input logic [imp_pkg::DATA_W-1:0] want);
    int unsigned gap;
    int unsigned n;
    int unsigned r;
    int unsigned c;
    int unsigned t;
    int unsigned k;
    logic [imp_pkg::DATA_W-1:0] acc;
    entry_t beat;
    gap = 0;
    while ($urandom_range(0, 99) < send_gap_pct) gap++;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= e;
    do @(posedge clk); while (!s_tready);
    elements_sent++;

    n = side_len(cur_dim);
    if (fill >= n * n) fill = 0;
    src_m[fill / n][fill % n] = e;
    fill++;
    if (fill == n * n) begin
      fill = 0;
      // seed with the identity for power zero, else with the matrix itself
      for (r = 0; r < n; r++)
        for (c = 0; c < n; c++)
          pow_m[r][c] = (cur_exp == '0) ? imp_pkg::DATA_W'(r == c) : src_m[r][c];
      // multiply on the right, wrapping at 32 bits
      for (k = 1; k < int'(cur_exp); k++) begin
        for (r = 0; r < n; r++) begin
          for (c = 0; c < n; c++) begin
            acc = '0;
            for (t = 0; t < n; t++) acc = acc + pow_m[r][t] * src_m[t][c];
            prod_m[r][c] = acc;
          end
        end
        for (r = 0; r < n; r++)
          for (c = 0; c < n; c++)
            pow_m[r][c] = prod_m[r][c];
      end
      if (typed) begin
        beat.value = want;
        beat.row   = '0;
        beat.col   = '0;
        beat.last  = 1'b1;
        power_beats_q.push_back(beat);
      end else begin
        for (r = 0; r < n; r++) begin
          for (c = 0; c < n; c++) begin
            beat.value = pow_m[r][c];
            beat.row   = 3'(r);
            beat.col   = 3'(c);
            beat.last  = (r == n - 1) && (c == n - 1);
            power_beats_q.push_back(beat);
          end
        end
      end
    end
  endtask

  // Receiver back-pressure, redrawn every cycle on the falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Output check: every taken beat against the oldest owed one, field by field
  always @(posedge clk) begin
    entry_t seen;
    entry_t owed;
    if (!rst && m_tvalid && m_tready) begin
      seen.value = m_tdata[31:0];
      seen.row   = m_tdata[34:32];
      seen.col   = m_tdata[37:35];
      seen.last  = m_tlast;
      if (power_beats_q.size() == 0) begin
        report_mismatch($sformatf("beat with nothing owed: value %h row %0d col %0d",
                                  seen.value, seen.row, seen.col));
      end else begin
        owed = power_beats_q.pop_front();
        if (seen.value !== owed.value)
          report_mismatch($sformatf("value at (%0d,%0d): got %h, want %h",
                                    owed.row, owed.col, seen.value, owed.value));
        if (seen.row !== owed.row)
          report_mismatch($sformatf("row: got %0d, want %0d", seen.row, owed.row));
        if (seen.col !== owed.col)
          report_mismatch($sformatf("col: got %0d, want %0d", seen.col, owed.col));
        if (seen.last !== owed.last)
          report_mismatch($sformatf("tlast at (%0d,%0d): got %b, want %b",
                                    owed.row, owed.col, seen.last, owed.last));
      end
    end
  end

  // Stimulus: reset, directed table, then random phases
  initial begin
    int unsigned i;
    int unsigned n;
    int unsigned k;
    int unsigned split;
    int unsigned phase;
    int unsigned r;
    logic [imp_pkg::DIM_W-1:0] d;

    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = imp_pkg::REG_DIM;
    cfg_data   = '0;
    mismatches = 0;
    elements_sent = 0;
    cur_dim    = imp_pkg::DIM_W'(1);
    cur_exp    = imp_pkg::EXP_W'(1);
    fill       = 0;
    set_idling(IDLE_NONE);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < PLAN_LEN; i++) begin
      case (PLAN[i].kind)
        ROW_DIM:  write_reg(imp_pkg::REG_DIM, PLAN[i].data[imp_pkg::CFG_W-1:0]);
        ROW_EXP:  write_reg(imp_pkg::REG_EXPONENT, PLAN[i].data[imp_pkg::CFG_W-1:0]);
        default:  send_element(PLAN[i].data, PLAN[i].typed, PLAN[i].want);
      endcase
    end

    // Random phases. The first three hit full size, oversize and zero dim;
    // after that small matrices dominate. Idling mode rotates per phase.
    phase = 0;
    while (elements_sent < ITEM_TARGET) begin
      set_idling(idling_e'(phase % 4));
      case (phase)
        0: d = imp_pkg::DIM_W'(imp_pkg::MAX_DIM);
        1: d = imp_pkg::DIM_W'($urandom_range(imp_pkg::MAX_DIM + 1, 15));
        2: d = '0;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 50)      d = imp_pkg::DIM_W'($urandom_range(1, 3));
          else if (r < 80) d = imp_pkg::DIM_W'($urandom_range(4, 5));
          else if (r < 96) d = imp_pkg::DIM_W'($urandom_range(6, 7));
          else             d = imp_pkg::DIM_W'($urandom_range(8, 15));
        end
      endcase
      n = side_len(d);
      write_reg(imp_pkg::REG_DIM, {12'($urandom), d});
      write_reg(imp_pkg::REG_EXPONENT, pick_exponent(n));

      repeat ((n >= 6) ? 1 : $urandom_range(1, 3)) begin
        // now and then an abandoned load, cut short by a dim rewrite
        if (n > 1 && $urandom_range(0, 99) < 12) begin
          repeat ($urandom_range(1, n * n - 1)) send_element(rand_element(), 1'b0, '0);
          write_reg(imp_pkg::REG_DIM, {12'($urandom), d});
        end
        split = (n > 1 && $urandom_range(0, 99) < 10) ? $urandom_range(1, n * n - 1) : 0;
        for (k = 0; k < n * n; k++) begin
          if (split != 0 && k == split) write_reg(imp_pkg::REG_EXPONENT, pick_exponent(n));
          send_element(rand_element(), 1'b0, '0);
        end
      end
      phase++;
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (power_beats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> integer_matrix_power.f
rtl/imp_pkg.sv
rtl/imp_ram.sv
rtl/imp_mac.sv
rtl/imp_seq.sv
rtl/integer_matrix_power.sv
rtl/imp_checker.sv
dv/integer_matrix_power_tb.sv
